@@ hdl/lrkr_pkg.sv @@
// lrkr_pkg: sizes, types and the count update word shared by the
// longest-run-with-replacements block; no dependencies
`timescale 1ns / 1ps

package lrkr_pkg;

  localparam int MAX_LEN  = 1024;
  localparam int ALPHABET = 26;

  localparam int LETTER_W = $clog2(ALPHABET);
  localparam int POS_W    = $clog2(MAX_LEN);
  localparam int LEN_W    = $clog2(MAX_LEN + 1);

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [LEN_W-1:0]    len_t;

  typedef struct packed {
    logic    inc_en;
    letter_t inc_letter;
    logic    dec_en;
    letter_t dec_letter;
    logic    clear;
  } cnt_upd_t;

endpackage

@@ hdl/lrkr_letter_store.sv @@
// lrkr_letter_store: window letter memory, one write and one read port,
// registered read with write-to-read forwarding; uses lrkr_pkg
`timescale 1ns / 1ps

module lrkr_letter_store
  import lrkr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  pos_t    wr_addr,
  input  letter_t wr_data,
  input  pos_t    rd_addr,
  output letter_t head_letter
);

  letter_t mem [MAX_LEN];
  letter_t rd_data_r;
  letter_t fwd_data_r;
  logic    fwd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r  <= mem[rd_addr];
    fwd_data_r <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else begin
      fwd_hit_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign head_letter = fwd_hit_r ? fwd_data_r : rd_data_r;

endmodule

@@ hdl/lrkr_counts.sv @@
// lrkr_counts: one count per letter with increment, decrement and clear,
// plus a select of the count of the incoming letter; uses lrkr_pkg
`timescale 1ns / 1ps

module lrkr_counts
  import lrkr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cnt_upd_t upd,
  input  letter_t  sel_letter,
  output len_t     sel_count
);

  len_t cnt_r   [ALPHABET];
  len_t cnt_nxt [ALPHABET];

  always_comb begin
    for (int i = 0; i < ALPHABET; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (upd.clear) begin
        cnt_nxt[i] = '0;
      end else begin
        if (upd.inc_en && (upd.inc_letter == LETTER_W'(i))) begin
          cnt_nxt[i] = cnt_nxt[i] + LEN_W'(1);
        end
        if (upd.dec_en && (upd.dec_letter == LETTER_W'(i))) begin
          cnt_nxt[i] = cnt_nxt[i] - LEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ALPHABET; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < ALPHABET; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  always_comb begin
    sel_count = '0;
    for (int i = 0; i < ALPHABET; i++) begin
      if (sel_letter == LETTER_W'(i)) begin
        sel_count = cnt_r[i];
      end
    end
  end

endmodule

@@ hdl/longest_run_with_k_replacements.sv @@
// longest_run_with_k_replacements: sliding window top level, window control,
// result register and checks; uses lrkr_pkg, lrkr_counts, lrkr_letter_store
`timescale 1ns / 1ps
//
//  channel | direction | handshake         | payload
//  in_     | in        | tvalid/tready     | tdata[4:0] letter, tlast last_letter
//  out_    | out       | tvalid/tready     | tdata[10:0] best_length, tlast string_done,
//          |           |                   | tuser overflow
//  cfg_    | in        | wr_en             | wr_data max_replacements
//
//  one word per cycle unless out_tready stalls; results appear the cycle after input
//  the oldest window letter is prefetched by a registered read of the letter store,
//  with forwarding when it is the letter written in the same cycle
//  in_tready follows out_tready while a result is held in the output register
//  reset clears counts, window pointers, best length and the limit; no clearing pass

module longest_run_with_k_replacements
  import lrkr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [4:0] letter
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [10:0] best_length
  output logic        out_tlast,
  output logic        out_tuser,  // [0] overflow
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data
);

  len_t     k_r;
  len_t     taken_r, taken_nxt;
  pos_t     start_r, start_nxt;
  len_t     top_r, top_nxt;
  len_t     best_r, best_nxt;
  logic     out_valid_r;
  len_t     out_best_r;
  logic     out_done_r;
  logic     out_ovf_r;

  logic     acc;
  letter_t  letter;
  logic     ovf;
  logic     take;
  len_t     sel_count;
  len_t     cnt_inc;
  len_t     top_calc;
  len_t     win_len;
  logic     drop;
  len_t     len_fin;
  len_t     best_calc;
  letter_t  head_letter;
  cnt_upd_t upd;

  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign letter    = in_tdata[LETTER_W-1:0];
  assign ovf       = (taken_r == LEN_W'(MAX_LEN));
  assign take      = acc && !ovf && (letter < LETTER_W'(ALPHABET));

  always_comb begin
    cnt_inc   = sel_count + LEN_W'(1);
    top_calc  = (cnt_inc > top_r) ? cnt_inc : top_r;
    win_len   = taken_r + LEN_W'(1) - {1'b0, start_r};
    drop      = (win_len > top_calc) && ((win_len - top_calc) > k_r);
    len_fin   = win_len - LEN_W'(drop);
    best_calc = (len_fin > best_r) ? len_fin : best_r;

    taken_nxt = taken_r;
    start_nxt = start_r;
    top_nxt   = top_r;
    best_nxt  = best_r;
    if (acc && in_tlast) begin
      taken_nxt = '0;
      start_nxt = '0;
      top_nxt   = '0;
      best_nxt  = '0;
    end else if (take) begin
      taken_nxt = taken_r + LEN_W'(1);
      start_nxt = start_r + POS_W'(drop);
      top_nxt   = top_calc;
      best_nxt  = best_calc;
    end

    upd.inc_en     = take;
    upd.inc_letter = letter;
    upd.dec_en     = take && drop;
    upd.dec_letter = head_letter;
    upd.clear      = acc && in_tlast;
  end

  lrkr_counts u_counts (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (upd),
    .sel_letter (letter),
    .sel_count  (sel_count)
  );

  lrkr_letter_store u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en       (take),
    .wr_addr     (taken_r[POS_W-1:0]),
    .wr_data     (letter),
    .rd_addr     (start_nxt),
    .head_letter (head_letter)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      taken_r     <= '0;
      start_r     <= '0;
      top_r       <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        k_r <= cfg_wr_data;
      end
      taken_r <= taken_nxt;
      start_r <= start_nxt;
      top_r   <= top_nxt;
      best_r  <= best_nxt;
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_best_r <= take ? best_calc : best_r;
      out_done_r <= in_tlast;
      out_ovf_r  <= ovf;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(16 - LEN_W){1'b0}}, out_best_r};
  assign out_tlast  = out_done_r;
  assign out_tuser  = out_ovf_r;

  a_start_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, start_r} <= taken_r)
    else $error("window start beyond letters taken");

  a_top_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= taken_r)
    else $error("top count exceeds letters taken");

  a_best_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    best_r <= taken_r)
    else $error("best length exceeds letters taken");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tlast) |=> (taken_r == '0 && best_r == '0))
    else $error("string state not cleared after last word");

endmodule
